/* sv/swsend_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window sender package
// Shared constants, codes and types of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package swsend_pkg;

   localparam int WINDOW_SIZE = 8;
   localparam int MAX_FRAMES  = 256;

   localparam int FRAME_W   = 8;
   localparam int COUNT_W   = 9;
   localparam int TICK_W    = 8;
   localparam int WIN_IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_IDX_TOTAL   = 1'b0;
   localparam logic CSR_IDX_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_NAK   = 2'd2,
      KIND_TICK  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_SEND  = 2'd0,
      ST_WAIT  = 2'd1,
      ST_ACKED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_SLIDE,
      BK_SCAN
   } bk_state_type;

   typedef struct packed {
      logic               is_start;
      logic               is_ack;
      logic               is_nak;
      logic               is_tick;
      logic [FRAME_W-1:0] frame;
   } cmd_type;

   function automatic logic [COUNT_W-1:0] frames_limit(input logic [COUNT_W-1:0] total);
      logic [COUNT_W-1:0] result;
      if (int'(total) > MAX_FRAMES) begin
         result = COUNT_W'(MAX_FRAMES);
      end else begin
         result = total;
      end
      return result;
   endfunction

endpackage

/* sv/swsend_front.sv */
// ----------------------------------------------------------------------------
// Sliding window sender front end
// Accepts command words, decodes their kind and hands them to the queue.
// ----------------------------------------------------------------------------
module swsend_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_kind,
   input  logic [swsend_pkg::FRAME_W-1:0]  req_frame_index,
   input  logic                            q_full,
   output logic                            push,
   output swsend_pkg::cmd_type             push_cmd
);

   logic                valid_ff;
   logic                valid_in;
   swsend_pkg::cmd_type cmd_ff;
   swsend_pkg::cmd_type cmd_in;
   logic                accept;

   assign busy     = valid_ff && q_full;
   assign accept   = start && !busy;
   assign push     = valid_ff && !q_full;
   assign push_cmd = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in        = 1'b1;
         cmd_in.is_start = 1'b0;
         cmd_in.is_ack   = 1'b0;
         cmd_in.is_nak   = 1'b0;
         cmd_in.is_tick  = 1'b0;
         cmd_in.frame    = req_frame_index;
         unique case (swsend_pkg::kind_type'(req_kind))
            swsend_pkg::KIND_START: cmd_in.is_start = 1'b1;
            swsend_pkg::KIND_ACK:   cmd_in.is_ack   = 1'b1;
            swsend_pkg::KIND_NAK:   cmd_in.is_nak   = 1'b1;
            swsend_pkg::KIND_TICK:  cmd_in.is_tick  = 1'b1;
            default:                cmd_in.is_tick  = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

/* sv/swsend_queue.sv */
// ----------------------------------------------------------------------------
// Sliding window sender command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module swsend_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  swsend_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output swsend_pkg::cmd_type pop_cmd
);

   swsend_pkg::cmd_type                    entry_ff [swsend_pkg::QUEUE_DEPTH];
   logic [swsend_pkg::Q_PTR_W-1:0]         wr_ptr_ff;
   logic [swsend_pkg::Q_PTR_W-1:0]         wr_ptr_in;
   logic [swsend_pkg::Q_PTR_W-1:0]         rd_ptr_ff;
   logic [swsend_pkg::Q_PTR_W-1:0]         rd_ptr_in;
   logic [swsend_pkg::Q_CNT_W-1:0]         count_ff;
   logic [swsend_pkg::Q_CNT_W-1:0]         count_in;
   logic                                   do_push;
   logic                                   do_pop;

   assign full      = (count_ff == swsend_pkg::Q_CNT_W'(swsend_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == swsend_pkg::Q_PTR_W'(swsend_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == swsend_pkg::Q_PTR_W'(swsend_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* sv/swsend_back.sv */
// ----------------------------------------------------------------------------
// Sliding window sender back end
// Applies each command to the window, slides it one slot per cycle and
// emits one send word per cycle for every slot marked to send, or a single idle final word when none is.
// ----------------------------------------------------------------------------
module swsend_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_not_empty,
   input  swsend_pkg::cmd_type             q_cmd,
   output logic                            q_pop,
   input  logic [swsend_pkg::COUNT_W-1:0]  total_frames,
   input  logic [swsend_pkg::TICK_W-1:0]   timeout_ticks,
   output logic                            rsp_valid,
   output logic                            rsp_send_valid,
   output logic [swsend_pkg::FRAME_W-1:0]  rsp_send_frame,
   output logic                            rsp_all_done,
   output logic                            rsp_bad_index,
   output logic                            rsp_last
);

   localparam int W = swsend_pkg::WINDOW_SIZE;

   swsend_pkg::bk_state_type          state_ff;
   swsend_pkg::bk_state_type          state_in;
   swsend_pkg::cmd_type               cmd_ff;
   swsend_pkg::cmd_type               cmd_in;
   swsend_pkg::status_type            status_ff [W];
   swsend_pkg::status_type            status_in [W];
   logic [swsend_pkg::TICK_W-1:0]     wait_ff [W];
   logic [swsend_pkg::TICK_W-1:0]     wait_in [W];
   logic [swsend_pkg::FRAME_W-1:0]    head_ff;
   logic [swsend_pkg::FRAME_W-1:0]    head_in;
   logic                              at_end_ff;
   logic                              at_end_in;
   logic                              done_ff;
   logic                              done_in;
   logic                              bad_ff;
   logic                              bad_in;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic                              rsp_send_valid_ff;
   logic                              rsp_send_valid_in;
   logic [swsend_pkg::FRAME_W-1:0]    rsp_send_frame_ff;
   logic [swsend_pkg::FRAME_W-1:0]    rsp_send_frame_in;
   logic                              rsp_all_done_ff;
   logic                              rsp_all_done_in;
   logic                              rsp_bad_index_ff;
   logic                              rsp_bad_index_in;
   logic                              rsp_last_ff;
   logic                              rsp_last_in;

   logic [swsend_pkg::COUNT_W-1:0]    frame_count;
   logic [swsend_pkg::TICK_W-1:0]     limit;
   logic [swsend_pkg::FRAME_W-1:0]    offset;
   logic [swsend_pkg::WIN_IDX_W-1:0]  offset_idx;
   logic                              in_window;
   logic [W-1:0]                      send_mask;
   logic [W-1:0]                      rest_mask;
   logic [swsend_pkg::WIN_IDX_W-1:0]  low_idx;
   logic                              all_acked;
   logic [swsend_pkg::TICK_W:0]       aged;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_send_valid = rsp_send_valid_ff;
   assign rsp_send_frame = rsp_send_frame_ff;
   assign rsp_all_done   = rsp_all_done_ff;
   assign rsp_bad_index  = rsp_bad_index_ff;
   assign rsp_last       = rsp_last_ff;

   assign frame_count = swsend_pkg::frames_limit(total_frames);
   assign limit       = (timeout_ticks == '0) ? swsend_pkg::TICK_W'(1) : timeout_ticks;
   assign offset      = cmd_ff.frame - head_ff;
   assign offset_idx  = offset[swsend_pkg::WIN_IDX_W-1:0];
   assign in_window   = (cmd_ff.frame >= head_ff)
                        && (offset < swsend_pkg::FRAME_W'(W))
                        && ({1'b0, cmd_ff.frame} < frame_count);

   always_comb begin
      all_acked = 1'b1;
      low_idx   = '0;
      for (int i = 0; i < W; i++) begin
         send_mask[i] = (status_ff[i] == swsend_pkg::ST_SEND);
         if (status_ff[i] != swsend_pkg::ST_ACKED) begin
            all_acked = 1'b0;
         end
      end
      for (int i = W - 1; i >= 0; i--) begin
         if (send_mask[i]) begin
            low_idx = swsend_pkg::WIN_IDX_W'(i);
         end
      end
      rest_mask          = send_mask;
      rest_mask[low_idx] = 1'b0;
   end

   always_comb begin
      state_in          = state_ff;
      cmd_in            = cmd_ff;
      status_in         = status_ff;
      wait_in           = wait_ff;
      head_in           = head_ff;
      at_end_in         = at_end_ff;
      done_in           = done_ff;
      bad_in            = bad_ff;
      q_pop             = 1'b0;
      aged              = '0;
      rsp_valid_in      = 1'b0;
      rsp_send_valid_in = rsp_send_valid_ff;
      rsp_send_frame_in = rsp_send_frame_ff;
      rsp_all_done_in   = rsp_all_done_ff;
      rsp_bad_index_in  = rsp_bad_index_ff;
      rsp_last_in       = rsp_last_ff;

      unique case (state_ff)
         swsend_pkg::BK_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = swsend_pkg::BK_EXEC;
            end
         end
         swsend_pkg::BK_EXEC: begin
            bad_in   = 1'b0;
            state_in = swsend_pkg::BK_SCAN;
            priority if (cmd_ff.is_start) begin
               head_in = '0;
               for (int i = 0; i < W; i++) begin
                  status_in[i] = (swsend_pkg::COUNT_W'(i) < frame_count)
                                 ? swsend_pkg::ST_SEND : swsend_pkg::ST_ACKED;
                  wait_in[i]   = '0;
               end
               at_end_in = (frame_count <= swsend_pkg::COUNT_W'(W));
               done_in   = (frame_count == '0);
            end else if (cmd_ff.is_ack || cmd_ff.is_nak) begin
               bad_in = !in_window;
               if (in_window && !done_ff) begin
                  wait_in[offset_idx] = '0;
                  if (cmd_ff.is_ack) begin
                     status_in[offset_idx] = swsend_pkg::ST_ACKED;
                     state_in              = swsend_pkg::BK_SLIDE;
                  end else begin
                     status_in[offset_idx] = swsend_pkg::ST_SEND;
                  end
               end
            end else begin
               if (!done_ff) begin
                  for (int i = 0; i < W; i++) begin
                     if (status_ff[i] == swsend_pkg::ST_WAIT) begin
                        aged = {1'b0, wait_ff[i]} + 1'b1;
                        if (aged >= {1'b0, limit}) begin
                           status_in[i] = swsend_pkg::ST_SEND;
                           wait_in[i]   = '0;
                        end else begin
                           wait_in[i] = aged[swsend_pkg::TICK_W-1:0];
                        end
                     end
                  end
               end
            end
         end
         swsend_pkg::BK_SLIDE: begin
            if (!at_end_ff && (status_ff[0] == swsend_pkg::ST_ACKED)) begin
               if (({2'b00, head_ff} + 10'(W)) >= {1'b0, frame_count}) begin
                  at_end_in = 1'b1;
               end else begin
                  for (int i = 1; i < W; i++) begin
                     status_in[i-1] = status_ff[i];
                     wait_in[i-1]   = wait_ff[i];
                  end
                  status_in[W-1] = swsend_pkg::ST_SEND;
                  wait_in[W-1]   = '0;
                  head_in        = head_ff + 1'b1;
               end
            end else begin
               if (at_end_ff && all_acked) begin
                  done_in = 1'b1;
               end
               state_in = swsend_pkg::BK_SCAN;
            end
         end
         swsend_pkg::BK_SCAN: begin
            rsp_valid_in     = 1'b1;
            rsp_all_done_in  = done_ff;
            rsp_bad_index_in = bad_ff;
            if (send_mask == '0) begin
               rsp_send_valid_in = 1'b0;
               rsp_send_frame_in = '0;
               rsp_last_in       = 1'b1;
               state_in          = swsend_pkg::BK_IDLE;
            end else begin
               status_in[low_idx] = swsend_pkg::ST_WAIT;
               wait_in[low_idx]   = '0;
               rsp_send_valid_in  = 1'b1;
               rsp_send_frame_in  = head_ff + swsend_pkg::FRAME_W'(low_idx);
               rsp_last_in        = (rest_mask == '0);
               if (rest_mask == '0) begin
                  state_in = swsend_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = swsend_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swsend_pkg::BK_IDLE;
         head_ff      <= '0;
         at_end_ff    <= 1'b1;
         done_ff      <= 1'b1;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < W; i++) begin
            status_ff[i] <= swsend_pkg::ST_ACKED;
            wait_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         at_end_ff    <= at_end_in;
         done_ff      <= done_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < W; i++) begin
            status_ff[i] <= status_in[i];
            wait_ff[i]   <= wait_in[i];
         end
      end
      cmd_ff            <= cmd_in;
      rsp_send_valid_ff <= rsp_send_valid_in;
      rsp_send_frame_ff <= rsp_send_frame_in;
      rsp_all_done_ff   <= rsp_all_done_in;
      rsp_bad_index_ff  <= rsp_bad_index_in;
      rsp_last_ff       <= rsp_last_in;
   end

endmodule

/* sv/sliding_window_sender.sv */
// ----------------------------------------------------------------------------
// Sliding window sender
// Selective-repeat sender window with a decoupled front end, a command queue
// and a back end that updates the window and emits send words.
// A command passes the front-end register and the queue; the back end pops
// it in its idle state, executes it, slides the window step by step after an
// in-window ACK, then scans and emits its result words from registers. The
// back end takes the next command only once its last result word is out.
// Reset: synchronous; all slots acked, head frame 0, message done, registers 1.
// ----------------------------------------------------------------------------
module sliding_window_sender (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_kind,
   input  logic [swsend_pkg::FRAME_W-1:0]      req_frame_index,
   output logic                                rsp_valid,
   output logic                                rsp_send_valid,
   output logic [swsend_pkg::FRAME_W-1:0]      rsp_send_frame,
   output logic                                rsp_all_done,
   output logic                                rsp_bad_index,
   output logic                                rsp_last,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [swsend_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [swsend_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [swsend_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                pready
);

   logic [swsend_pkg::COUNT_W-1:0] total_frames_ff;
   logic [swsend_pkg::COUNT_W-1:0] total_frames_in;
   logic [swsend_pkg::TICK_W-1:0]  timeout_ticks_ff;
   logic [swsend_pkg::TICK_W-1:0]  timeout_ticks_in;
   logic                           csr_write;
   logic                           csr_index;

   logic                           q_push;
   swsend_pkg::cmd_type            q_push_cmd;
   logic                           q_full;
   logic                           q_pop;
   logic                           q_not_empty;
   swsend_pkg::cmd_type            q_pop_cmd;

   assign pready    = 1'b1;
   assign csr_index = paddr[swsend_pkg::CSR_ADDR_W-1];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      total_frames_in  = total_frames_ff;
      timeout_ticks_in = timeout_ticks_ff;
      if (csr_write) begin
         unique case (csr_index)
            swsend_pkg::CSR_IDX_TOTAL:   total_frames_in  = pwdata[swsend_pkg::COUNT_W-1:0];
            swsend_pkg::CSR_IDX_TIMEOUT: timeout_ticks_in = pwdata[swsend_pkg::TICK_W-1:0];
            default:                     total_frames_in  = total_frames_ff;
         endcase
      end
      unique case (csr_index)
         swsend_pkg::CSR_IDX_TOTAL:
            prdata = swsend_pkg::CSR_DATA_W'(total_frames_ff);
         swsend_pkg::CSR_IDX_TIMEOUT:
            prdata = swsend_pkg::CSR_DATA_W'(timeout_ticks_ff);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_frames_ff  <= swsend_pkg::COUNT_W'(1);
         timeout_ticks_ff <= swsend_pkg::TICK_W'(1);
      end else begin
         total_frames_ff  <= total_frames_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   swsend_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_frame_index (req_frame_index),
      .q_full          (q_full),
      .push            (q_push),
      .push_cmd        (q_push_cmd)
   );

   swsend_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_cmd   (q_pop_cmd)
   );

   swsend_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_cmd          (q_pop_cmd),
      .q_pop          (q_pop),
      .total_frames   (total_frames_ff),
      .timeout_ticks  (timeout_ticks_ff),
      .rsp_valid      (rsp_valid),
      .rsp_send_valid (rsp_send_valid),
      .rsp_send_frame (rsp_send_frame),
      .rsp_all_done   (rsp_all_done),
      .rsp_bad_index  (rsp_bad_index),
      .rsp_last       (rsp_last)
   );

endmodule

/* sv/swsend_checker.sv */
// ----------------------------------------------------------------------------
// Sliding window sender checker
// Port-level assertions on the result words, bound to the top level.
// ----------------------------------------------------------------------------
module swsend_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [1:0]                          req_kind,
   input logic [swsend_pkg::FRAME_W-1:0]      req_frame_index,
   input logic                                rsp_valid,
   input logic                                rsp_send_valid,
   input logic [swsend_pkg::FRAME_W-1:0]      rsp_send_frame,
   input logic                                rsp_all_done,
   input logic                                rsp_bad_index,
   input logic                                rsp_last,
   input logic                                psel,
   input logic                                penable,
   input logic                                pwrite,
   input logic [swsend_pkg::CSR_ADDR_W-1:0]   paddr,
   input logic [swsend_pkg::CSR_DATA_W-1:0]   pwdata,
   input logic [swsend_pkg::CSR_DATA_W-1:0]   prdata,
   input logic                                pready
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result word seen right after reset.");

   a_idle_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_send_valid) |-> (rsp_last && rsp_send_frame == '0))
      else $error("Idle result word is not a clean final word.");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> (rsp_valid && rsp_send_valid))
      else $error("Result burst broke off before its final word.");

   a_flags_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> ($stable(rsp_all_done) && $stable(rsp_bad_index)))
      else $error("Status flags changed within one burst.");

endmodule

bind sliding_window_sender swsend_checker u_swsend_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window sender testbench
// Sends start, ACK, NAK and tick commands under several register settings,
// predicts the send words of every accepted command with a window tracker
// of its own and compares every result word field by field, in order.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [swsend_pkg::CSR_ADDR_W-1:0] ADDR_TOTAL   =
      {swsend_pkg::CSR_IDX_TOTAL, 2'b00};
   localparam logic [swsend_pkg::CSR_ADDR_W-1:0] ADDR_TIMEOUT =
      {swsend_pkg::CSR_IDX_TIMEOUT, 2'b00};

   typedef struct packed {
      logic                          send_valid;
      logic [swsend_pkg::FRAME_W-1:0] send_frame;
      logic                          all_done;
      logic                          bad_index;
      logic                          last;
   } send_word_type;

   class window_tracker;
      logic [swsend_pkg::COUNT_W-1:0] total_frames;
      logic [swsend_pkg::TICK_W-1:0]  timeout_ticks;
      swsend_pkg::status_type         slot_st[swsend_pkg::WINDOW_SIZE];
      logic [swsend_pkg::TICK_W-1:0]  slot_age[swsend_pkg::WINDOW_SIZE];
      logic [swsend_pkg::FRAME_W-1:0] head;
      bit                             at_end;
      bit                             done;
      send_word_type                  pending_words[$];
      int                             errors;

      function new();
         total_frames  = swsend_pkg::COUNT_W'(1);
         timeout_ticks = swsend_pkg::TICK_W'(1);
         for (int i = 0; i < swsend_pkg::WINDOW_SIZE; i++) begin
            slot_st[i]  = swsend_pkg::ST_ACKED;
            slot_age[i] = '0;
         end
         head   = '0;
         at_end = 1'b1;
         done   = 1'b1;
         errors = 0;
      endfunction

      function int frame_count();
         return (int'(total_frames) > swsend_pkg::MAX_FRAMES)
                ? swsend_pkg::MAX_FRAMES : int'(total_frames);
      endfunction

      function bit window_clear();
         foreach (slot_st[i]) begin
            if (slot_st[i] != swsend_pkg::ST_ACKED) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void slide();
         while (!at_end && slot_st[0] == swsend_pkg::ST_ACKED) begin
            if (int'(head) + swsend_pkg::WINDOW_SIZE >= frame_count()) begin
               at_end = 1'b1;
            end else begin
               for (int i = 1; i < swsend_pkg::WINDOW_SIZE; i++) begin
                  slot_st[i-1]  = slot_st[i];
                  slot_age[i-1] = slot_age[i];
               end
               slot_st[swsend_pkg::WINDOW_SIZE-1]  = swsend_pkg::ST_SEND;
               slot_age[swsend_pkg::WINDOW_SIZE-1] = '0;
               head++;
            end
         end
      endfunction

      function void note_command(swsend_pkg::kind_type kind,
                                 logic [swsend_pkg::FRAME_W-1:0] fidx);
         int            n;
         int            off;
         int            limit;
         bit            bad;
         send_word_type words[$];
         send_word_type w;
         n   = frame_count();
         bad = 1'b0;
         case (kind)
            swsend_pkg::KIND_START: begin
               head = '0;
               for (int i = 0; i < swsend_pkg::WINDOW_SIZE; i++) begin
                  slot_st[i]  = (i < n) ? swsend_pkg::ST_SEND : swsend_pkg::ST_ACKED;
                  slot_age[i] = '0;
               end
               at_end = (n <= swsend_pkg::WINDOW_SIZE);
               done   = (n == 0);
            end
            swsend_pkg::KIND_ACK, swsend_pkg::KIND_NAK: begin
               off = int'(fidx) - int'(head);
               bad = !(off >= 0 && off < swsend_pkg::WINDOW_SIZE && int'(fidx) < n);
               if (!bad && !done) begin
                  slot_age[off] = '0;
                  if (kind == swsend_pkg::KIND_ACK) begin
                     slot_st[off] = swsend_pkg::ST_ACKED;
                     slide();
                     if (at_end && window_clear()) done = 1'b1;
                  end else begin
                     slot_st[off] = swsend_pkg::ST_SEND;
                  end
               end
            end
            default: begin
               if (!done) begin
                  limit = (timeout_ticks == '0) ? 1 : int'(timeout_ticks);
                  for (int i = 0; i < swsend_pkg::WINDOW_SIZE; i++) begin
                     if (slot_st[i] == swsend_pkg::ST_WAIT) begin
                        slot_age[i]++;
                        if (int'(slot_age[i]) >= limit) begin
                           slot_st[i]  = swsend_pkg::ST_SEND;
                           slot_age[i] = '0;
                        end
                     end
                  end
               end
            end
         endcase
         for (int i = 0; i < swsend_pkg::WINDOW_SIZE; i++) begin
            if (slot_st[i] == swsend_pkg::ST_SEND) begin
               slot_st[i]   = swsend_pkg::ST_WAIT;
               slot_age[i]  = '0;
               w            = '0;
               w.send_valid = 1'b1;
               w.send_frame = head + swsend_pkg::FRAME_W'(i);
               words.push_back(w);
            end
         end
         if (words.size() == 0) words.push_back(send_word_type'('0));
         foreach (words[i]) begin
            words[i].all_done  = done;
            words[i].bad_index = bad;
            words[i].last      = (i == words.size() - 1);
            pending_words.push_back(words[i]);
         end
      endfunction

      function logic [swsend_pkg::FRAME_W-1:0] pick_live_frame(int lowest_pct);
         int live[$];
         for (int i = 0; i < swsend_pkg::WINDOW_SIZE; i++) begin
            if (slot_st[i] != swsend_pkg::ST_ACKED && int'(head) + i < frame_count())
               live.push_back(int'(head) + i);
         end
         if (done || live.size() == 0)
            return swsend_pkg::FRAME_W'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < lowest_pct) return swsend_pkg::FRAME_W'(live[0]);
         return swsend_pkg::FRAME_W'(live[$urandom_range(0, live.size() - 1)]);
      endfunction

      function void compare(string field, int expv, int actv);
         if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
            errors++;
         end
      endfunction

      function void check_word(send_word_type got);
         send_word_type want;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, got frame %0d valid %0d",
                     $time, got.send_frame, got.send_valid);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         compare("send_valid", want.send_valid, got.send_valid);
         compare("send_frame", want.send_frame, got.send_frame);
         compare("all_done", want.all_done, got.all_done);
         compare("bad_index", want.bad_index, got.bad_index);
         compare("last", want.last, got.last);
      endfunction
   endclass

   logic                              clock;
   logic                              reset           = 1'b1;
   logic                              start           = 1'b0;
   logic                              busy;
   logic [1:0]                        req_kind        = '0;
   logic [swsend_pkg::FRAME_W-1:0]    req_frame_index = '0;
   logic                              rsp_valid;
   logic                              rsp_send_valid;
   logic [swsend_pkg::FRAME_W-1:0]    rsp_send_frame;
   logic                              rsp_all_done;
   logic                              rsp_bad_index;
   logic                              rsp_last;
   logic                              psel            = 1'b0;
   logic                              penable         = 1'b0;
   logic                              pwrite          = 1'b0;
   logic [swsend_pkg::CSR_ADDR_W-1:0] paddr           = '0;
   logic [swsend_pkg::CSR_DATA_W-1:0] pwdata          = '0;
   logic [swsend_pkg::CSR_DATA_W-1:0] prdata;
   logic                              pready;

   window_tracker tracker;
   int            gap_limit;

   sliding_window_sender uut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         tracker.check_word({rsp_send_valid, rsp_send_frame, rsp_all_done,
                             rsp_bad_index, rsp_last});
   end

   task automatic issue_command(input swsend_pkg::kind_type kind,
                                input logic [swsend_pkg::FRAME_W-1:0] fidx);
      int gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_frame_index <= fidx;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_command(kind, fidx);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (tracker.pending_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic [swsend_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [swsend_pkg::CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      if (addr == ADDR_TOTAL) tracker.total_frames = data[swsend_pkg::COUNT_W-1:0];
      else tracker.timeout_ticks = data[swsend_pkg::TICK_W-1:0];
   endtask

   function automatic logic [swsend_pkg::COUNT_W-1:0] pick_total();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return swsend_pkg::COUNT_W'(1);
         2: return swsend_pkg::COUNT_W'(swsend_pkg::WINDOW_SIZE);
         3: return swsend_pkg::COUNT_W'(swsend_pkg::WINDOW_SIZE + 1);
         4: return swsend_pkg::COUNT_W'($urandom_range(2, 40));
         default: return swsend_pkg::COUNT_W'($urandom_range(257, 511));
      endcase
   endfunction

   function automatic logic [swsend_pkg::TICK_W-1:0] pick_timeout();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return swsend_pkg::TICK_W'(1);
         2: return swsend_pkg::TICK_W'(255);
         default: return swsend_pkg::TICK_W'($urandom_range(2, 5));
      endcase
   endfunction

   task automatic run_phase(input logic [swsend_pkg::COUNT_W-1:0] total,
                            input logic [swsend_pkg::TICK_W-1:0] tmo,
                            input int count, input int ack_pct, input int in_order_pct);
      int r;
      int other;
      other     = 100 - ack_pct;
      gap_limit = ($urandom_range(0, 2) == 0) ? 0 : 16;
      csr_write(ADDR_TOTAL, swsend_pkg::CSR_DATA_W'(total));
      csr_write(ADDR_TIMEOUT, swsend_pkg::CSR_DATA_W'(tmo));
      issue_command(swsend_pkg::KIND_START, swsend_pkg::FRAME_W'($urandom));
      for (int j = 0; j < count; j++) begin
         r = $urandom_range(0, 99);
         if (tracker.done && r < 30)
            issue_command(swsend_pkg::KIND_START, swsend_pkg::FRAME_W'($urandom));
         else if (r < ack_pct)
            issue_command(swsend_pkg::KIND_ACK, tracker.pick_live_frame(in_order_pct));
         else if (r < ack_pct + other / 3)
            issue_command(swsend_pkg::KIND_NAK, tracker.pick_live_frame(0));
         else if (r < ack_pct + 2 * other / 3)
            issue_command(swsend_pkg::KIND_TICK, swsend_pkg::FRAME_W'($urandom));
         else
            issue_command(swsend_pkg::kind_type'($urandom_range(0, 3)),
                          swsend_pkg::FRAME_W'($urandom));
      end
      settle();
   endtask

   initial begin
      tracker   = new();
      gap_limit = 16;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Finished message after reset: state holds, out-of-window still flagged.
      issue_command(swsend_pkg::KIND_ACK, 8'd0);
      issue_command(swsend_pkg::KIND_NAK, 8'd0);
      issue_command(swsend_pkg::KIND_TICK, 8'd0);
      issue_command(swsend_pkg::KIND_ACK, 8'd255);
      settle();

      // Empty message, zero timeout.
      csr_write(ADDR_TOTAL, 0);
      csr_write(ADDR_TIMEOUT, 0);
      issue_command(swsend_pkg::KIND_START, 8'd0);
      issue_command(swsend_pkg::KIND_NAK, 8'd0);
      settle();

      // Short message: resend on tick, NAK on an acked slot, slide to the end.
      csr_write(ADDR_TOTAL, 3);
      issue_command(swsend_pkg::KIND_START, 8'd0);
      issue_command(swsend_pkg::KIND_TICK, 8'd0);
      issue_command(swsend_pkg::KIND_NAK, 8'd1);
      issue_command(swsend_pkg::KIND_ACK, 8'd3);
      issue_command(swsend_pkg::KIND_ACK, 8'd255);
      issue_command(swsend_pkg::KIND_ACK, 8'd1);
      issue_command(swsend_pkg::KIND_NAK, 8'd1);
      issue_command(swsend_pkg::KIND_ACK, 8'd0);
      issue_command(swsend_pkg::KIND_ACK, 8'd1);
      issue_command(swsend_pkg::KIND_ACK, 8'd2);
      issue_command(swsend_pkg::KIND_TICK, 8'd0);
      issue_command(swsend_pkg::KIND_NAK, 8'd2);
      settle();

      // Full-size message with the longest timeout.
      csr_write(ADDR_TOTAL, 256);
      csr_write(ADDR_TIMEOUT, 255);
      issue_command(swsend_pkg::KIND_START, 8'd0);
      issue_command(swsend_pkg::KIND_TICK, 8'd0);
      issue_command(swsend_pkg::KIND_ACK, 8'd0);
      issue_command(swsend_pkg::KIND_NAK, 8'd7);
      issue_command(swsend_pkg::KIND_ACK, 8'd128);
      settle();

      repeat (3) run_phase(pick_total(), pick_timeout(), 15, 50, 50);
      run_phase(9'd511, swsend_pkg::TICK_W'($urandom_range(1, 6)), 260, 90, 75);
      repeat (3) run_phase(pick_total(), pick_timeout(), 15, 50, 50);

      settle();
      repeat (32) @(posedge clock);
      if (tracker.pending_words.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time,
                  tracker.pending_words.size());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

/* filelist.f */
sv/swsend_pkg.sv
sv/swsend_front.sv
sv/swsend_queue.sv
sv/swsend_back.sv
sv/sliding_window_sender.sv
sv/swsend_checker.sv
verif/tb.sv
